### rtl/srf_pkg.sv
// srf_pkg: shared types, constants and helpers for the sample ring FIFO.
// No dependencies; used by srf_ctrl and sample_ring_fifo_top.
package srf_pkg;

    // Ring size (one slot always kept free) and burst cap
    localparam int SLOTS     = 1024;
    localparam int MAX_BURST = 64;

    // Field widths fixed by the interface
    localparam int CMD_W  = 2;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;
    localparam int OCC_W  = 10;

    // Derived widths
    localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMP_W = ((PTR_W > LEN_W + 1) ? PTR_W : LEN_W + 1) + 1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_READ
    } state_t;

    // One result item
    typedef struct packed {
        logic              accepted;
        logic [DATA_W-1:0] sample_out;
        logic              sample_valid;
        logic              last;
        logic [OCC_W-1:0]  occupancy;
    } res_t;

    // Advance a ring pointer with wrap at SLOTS
    function automatic ptr_t next_slot(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(SLOTS - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

endpackage

### rtl/srf_ram.sv
// srf_ram: generic simple dual-port synchronous RAM, one write port and
// one read port with registered read data. No dependencies.
module srf_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         q
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Read port, data held when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
            q <= mem[raddr];
    end

endmodule

### rtl/srf_ctrl.sv
// srf_ctrl: command sequencer for the sample ring FIFO: pointers, occupancy,
// block bookkeeping, fill and read bursts over the sample RAM.
// Depends on srf_pkg.
module srf_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    // request side
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic [srf_pkg::CMD_W-1:0]  command,
    input  logic [srf_pkg::DATA_W-1:0] sample_value,
    input  logic [srf_pkg::LEN_W-1:0]  count,
    input  logic                       block_start,
    // result side
    input  logic                       out_ready,
    output logic                       res_load,
    output srf_pkg::res_t              res,
    // sample RAM
    output logic                       ram_we,
    output srf_pkg::ptr_t              ram_waddr,
    output logic [srf_pkg::DATA_W-1:0] ram_wdata,
    output logic                       ram_re,
    output srf_pkg::ptr_t              ram_raddr,
    input  logic [srf_pkg::DATA_W-1:0] ram_q
);

    srf_pkg::state_t           state_reg, state_next;
    srf_pkg::ptr_t             wp_reg, wp_next;
    srf_pkg::ptr_t             rp_reg, rp_next;
    srf_pkg::ptr_t             occ_reg, occ_next;
    logic                      blk_acc_reg, blk_acc_next;
    srf_pkg::len_t             blk_rem_reg, blk_rem_next;
    srf_pkg::len_t             op_rem_reg, op_rem_next;
    logic [srf_pkg::DATA_W-1:0] fill_val_reg, fill_val_next;
    logic                      rd_pend_reg, rd_pend_next;
    logic                      pend_last_reg, pend_last_next;

    logic                      take;
    srf_pkg::len_t             len;
    logic [srf_pkg::CMP_W-1:0] free_w;
    logic [srf_pkg::CMP_W-1:0] occ_w;
    logic [srf_pkg::CMP_W-1:0] len_w;
    logic [srf_pkg::CMP_W-1:0] owed_w;
    logic                      fit_blk;
    logic                      fit_fill;
    logic                      fit_read;
    logic                      blk_open;
    logic                      blk_go;
    srf_pkg::len_t             blk_rem;
    logic                      load_out;
    logic                      issue;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srf_pkg::ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            occ_reg       <= '0;
            blk_acc_reg   <= 1'b0;
            blk_rem_reg   <= '0;
            op_rem_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            occ_reg       <= occ_next;
            blk_acc_reg   <= blk_acc_next;
            blk_rem_reg   <= blk_rem_next;
            op_rem_reg    <= op_rem_next;
            rd_pend_reg   <= rd_pend_next;
            pend_last_reg <= pend_last_next;
        end
    end

    // Fill value, payload only
    always_ff @(posedge clk)
    begin
        fill_val_reg <= fill_val_next;
    end

    // Space checks
    always_comb
    begin
        len      = (count > srf_pkg::LEN_W'(srf_pkg::MAX_BURST)) ?
                   srf_pkg::LEN_W'(srf_pkg::MAX_BURST) : count;
        occ_w    = srf_pkg::CMP_W'(occ_reg);
        free_w   = srf_pkg::CMP_W'(srf_pkg::SLOTS - 1) - occ_w;
        len_w    = srf_pkg::CMP_W'(len);
        owed_w   = blk_acc_reg ? srf_pkg::CMP_W'(blk_rem_reg) : '0;
        fit_blk  = (len_w <= free_w);
        fit_fill = (len_w + owed_w <= free_w);
        fit_read = (len_w <= occ_w);
    end

    // Next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        occ_next       = occ_reg;
        blk_acc_next   = blk_acc_reg;
        blk_rem_next   = blk_rem_reg;
        op_rem_next    = op_rem_reg;
        fill_val_next  = fill_val_reg;
        rd_pend_next   = rd_pend_reg;
        pend_last_next = pend_last_reg;

        req_stall = !((state_reg == srf_pkg::ST_IDLE) && out_ready);
        take      = req_valid && !req_stall;

        ram_we    = 1'b0;
        ram_waddr = wp_reg;
        ram_wdata = sample_value;
        ram_re    = 1'b0;
        ram_raddr = rp_reg;

        res_load         = 1'b0;
        res.accepted     = 1'b0;
        res.sample_out   = '0;
        res.sample_valid = 1'b0;
        res.last         = 1'b1;
        res.occupancy    = srf_pkg::OCC_W'(occ_reg);

        blk_open = block_start || (blk_rem_reg != '0);
        blk_go   = block_start ? fit_blk : blk_acc_reg;
        blk_rem  = block_start ? len : blk_rem_reg;
        load_out = 1'b0;
        issue    = 1'b0;

        case (state_reg)
            srf_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    res_load = 1'b1;
                    case (command)
                        srf_pkg::CMD_WRITE:
                        begin
                            // block element: length checked on the start element
                            res.accepted = blk_open && blk_go;
                            if (block_start)
                                blk_acc_next = fit_blk;
                            blk_rem_next = blk_rem;
                            if (blk_rem != '0)
                            begin
                                blk_rem_next = blk_rem - 1'b1;
                                if (blk_go)
                                begin
                                    ram_we        = 1'b1;
                                    wp_next       = srf_pkg::next_slot(wp_reg);
                                    occ_next      = occ_reg + 1'b1;
                                    res.occupancy = srf_pkg::OCC_W'(occ_next);
                                end
                            end
                        end
                        srf_pkg::CMD_FILL:
                        begin
                            // result goes out now with the final occupancy
                            res.accepted = fit_fill;
                            if (fit_fill)
                            begin
                                occ_next      = srf_pkg::PTR_W'(occ_w + len_w);
                                res.occupancy = srf_pkg::OCC_W'(occ_w + len_w);
                                if (len != '0)
                                begin
                                    state_next    = srf_pkg::ST_FILL;
                                    op_rem_next   = len;
                                    fill_val_next = sample_value;
                                end
                            end
                        end
                        srf_pkg::CMD_READ:
                        begin
                            res.accepted = fit_read;
                            if (fit_read && (len != '0))
                            begin
                                res_load    = 1'b0;
                                state_next  = srf_pkg::ST_READ;
                                op_rem_next = len;
                            end
                        end
                        default:
                        begin
                            res.accepted = 1'b0;
                        end
                    endcase
                end
            end
            srf_pkg::ST_FILL:
            begin
                // one write per cycle
                ram_we      = 1'b1;
                ram_wdata   = fill_val_reg;
                wp_next     = srf_pkg::next_slot(wp_reg);
                op_rem_next = op_rem_reg - 1'b1;
                if (op_rem_reg == srf_pkg::LEN_W'(1))
                    state_next = srf_pkg::ST_IDLE;
            end
            srf_pkg::ST_READ:
            begin
                // RAM data waiting in ram_q moves to the output register
                load_out = rd_pend_reg && out_ready;
                issue    = (op_rem_reg != '0) && (!rd_pend_reg || load_out);
                if (load_out)
                begin
                    res_load         = 1'b1;
                    res.accepted     = 1'b1;
                    res.sample_out   = ram_q;
                    res.sample_valid = 1'b1;
                    res.last         = pend_last_reg;
                    rd_pend_next     = 1'b0;
                end
                if (issue)
                begin
                    ram_re         = 1'b1;
                    rp_next        = srf_pkg::next_slot(rp_reg);
                    occ_next       = occ_reg - 1'b1;
                    op_rem_next    = op_rem_reg - 1'b1;
                    pend_last_next = (op_rem_reg == srf_pkg::LEN_W'(1));
                    rd_pend_next   = 1'b1;
                end
                if (load_out && (op_rem_reg == '0))
                    state_next = srf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = srf_pkg::ST_IDLE;
            end
        endcase
    end

    // Occupancy never passes the usable capacity
    a_occ_cap: assert property (@(posedge clk) disable iff (!rst_n)
        srf_pkg::CMP_W'(occ_reg) <= srf_pkg::CMP_W'(srf_pkg::SLOTS - 1))
        else $error("occupancy above capacity");

    // Write and read bursts never overlap on the RAM
    a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("RAM read and write in the same cycle");

    // Pending read data only exists inside a read burst
    a_pend_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == srf_pkg::ST_READ))
        else $error("read data pending outside read burst");

    // A read issue always leaves data pending for the next cycle
    a_issue_pend: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> rd_pend_reg)
        else $error("issued read lost");

endmodule

### rtl/sample_ring_fifo_top.sv
// Sample ring FIFO, top level: output result register, sample RAM and sequencer.
// Depends on srf_pkg, srf_ram and srf_ctrl.
//
// Circular store of SLOTS 32-bit samples with one slot kept empty (SLOTS-1
// usable). A write-block element stores at most one sample. A fill of n
// samples returns its result at once and then occupies the single RAM write
// port, one sample per cycle, during which no request is taken; the next
// request is taken once the fill is done. A read of n samples returns n
// results, one per cycle when the result side does not stall; the first is
// loaded after the move to the read state and the registered RAM read. The
// next request is taken once the last result is loaded. Rejected or empty
// requests give one result. Requests are taken only while no burst is in
// progress and the result register can take a result. The sample RAM needs
// no clearing after reset: samples are only read once written.
module sample_ring_fifo_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic [srf_pkg::CMD_W-1:0]  command,
    input  logic [srf_pkg::DATA_W-1:0] sample_value,
    input  logic [srf_pkg::LEN_W-1:0]  count,
    input  logic                       block_start,
    output logic                       res_valid,
    input  logic                       res_stall,
    output logic                       accepted,
    output logic [srf_pkg::DATA_W-1:0] sample_out,
    output logic                       sample_valid,
    output logic                       last,
    output logic [srf_pkg::OCC_W-1:0]  occupancy
);

    logic                       res_valid_reg, res_valid_next;
    srf_pkg::res_t              res_data_reg, res_data_next;
    logic                       out_ready;
    logic                       res_load;
    srf_pkg::res_t              res;
    logic                       ram_we;
    srf_pkg::ptr_t              ram_waddr;
    logic [srf_pkg::DATA_W-1:0] ram_wdata;
    logic                       ram_re;
    srf_pkg::ptr_t              ram_raddr;
    logic [srf_pkg::DATA_W-1:0] ram_q;

    srf_ram #(
        .DEPTH (srf_pkg::SLOTS),
        .WIDTH (srf_pkg::DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .q     (ram_q)
    );

    srf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .command      (command),
        .sample_value (sample_value),
        .count        (count),
        .block_start  (block_start),
        .out_ready    (out_ready),
        .res_load     (res_load),
        .res          (res),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_q        (ram_q)
    );

    // Result register: free when empty or being taken this cycle
    always_comb
    begin
        out_ready      = !res_valid_reg || !res_stall;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
            res_data_next  = res;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid    = res_valid_reg;
    assign accepted     = res_data_reg.accepted;
    assign sample_out   = res_data_reg.sample_out;
    assign sample_valid = res_data_reg.sample_valid;
    assign last         = res_data_reg.last;
    assign occupancy    = res_data_reg.occupancy;

endmodule

### verif/sample_ring_fifo_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for sample_ring_fifo_top: directed and random requests,
// results predicted by an in-bench ring model. Depends on srf_pkg and the RTL.
module sample_ring_fifo_top_test;

    // Command code outside the defined set; the block must reject it
    localparam logic [srf_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 230;
    localparam int SETTLE_CYCLES   = 80;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_stall;
    logic [srf_pkg::CMD_W-1:0]  command = srf_pkg::CMD_WRITE;
    logic [srf_pkg::DATA_W-1:0] sample_value = '0;
    logic [srf_pkg::LEN_W-1:0]  count = '0;
    logic                       block_start = 1'b0;
    logic                       res_valid;
    logic                       res_stall = 1'b0;
    logic                       accepted;
    logic [srf_pkg::DATA_W-1:0] sample_out;
    logic                       sample_valid;
    logic                       last;
    logic [srf_pkg::OCC_W-1:0]  occupancy;

    // Ring model state
    logic [srf_pkg::DATA_W-1:0] ring_words [srf_pkg::SLOTS];
    int                         wr_slot;
    int                         rd_slot;
    bit                         blk_taken;
    int                         blk_left;

    srf_pkg::res_t              pending_results [$];
    int                         err_count;
    bit                         calm;

    sample_ring_fifo_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .command      (command),
        .sample_value (sample_value),
        .count        (count),
        .block_start  (block_start),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .accepted     (accepted),
        .sample_out   (sample_out),
        .sample_valid (sample_valid),
        .last         (last),
        .occupancy    (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        #20_000_000;
        $display("sample_ring_fifo_top_test: errors");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic int ring_used();
        return (wr_slot >= rd_slot) ? wr_slot - rd_slot
                                    : srf_pkg::SLOTS - rd_slot + wr_slot;
    endfunction

    function automatic int ring_free();
        return srf_pkg::SLOTS - ring_used() - 1;
    endfunction

    task automatic ring_push(input logic [srf_pkg::DATA_W-1:0] v);
        ring_words[wr_slot] = v;
        wr_slot = (wr_slot + 1 >= srf_pkg::SLOTS) ? 0 : wr_slot + 1;
    endtask

    task automatic queue_result(input bit acc, input logic [srf_pkg::DATA_W-1:0] s,
                                input bit sv, input bit lst);
        srf_pkg::res_t r;
        r.accepted     = acc;
        r.sample_out   = s;
        r.sample_valid = sv;
        r.last         = lst;
        r.occupancy    = srf_pkg::OCC_W'(ring_used());
        pending_results.push_back(r);
    endtask

    // Work out the results of one accepted request and update the ring model
    task automatic predict_request(input logic [srf_pkg::CMD_W-1:0] cmd,
                                   input logic [srf_pkg::DATA_W-1:0] val,
                                   input logic [srf_pkg::LEN_W-1:0] cnt,
                                   input logic start);
        int  n;
        int  owed;
        int  avail;
        bit  acc;
        n = (int'(cnt) > srf_pkg::MAX_BURST) ? srf_pkg::MAX_BURST : int'(cnt);
        case (cmd)
            srf_pkg::CMD_WRITE:
            begin
                if (start)
                begin
                    blk_left  = n;
                    blk_taken = (n <= ring_free());
                end
                if (!start && blk_left == 0)
                    queue_result(1'b0, '0, 1'b0, 1'b1);    // stray element
                else
                begin
                    acc = blk_taken;
                    if (blk_left > 0)
                    begin
                        blk_left--;
                        if (blk_taken)
                            ring_push(val);
                    end
                    queue_result(acc, '0, 1'b0, 1'b1);
                end
            end
            srf_pkg::CMD_FILL:
            begin
                // space owed to an open accepted block is reserved
                owed  = blk_taken ? blk_left : 0;
                avail = (ring_free() > owed) ? ring_free() - owed : 0;
                if (n > avail)
                    queue_result(1'b0, '0, 1'b0, 1'b1);
                else
                begin
                    for (int i = 0; i < n; i++)
                        ring_push(val);
                    queue_result(1'b1, '0, 1'b0, 1'b1);
                end
            end
            srf_pkg::CMD_READ:
            begin
                if (n > ring_used())
                    queue_result(1'b0, '0, 1'b0, 1'b1);
                else if (n == 0)
                    queue_result(1'b1, '0, 1'b0, 1'b1);
                else
                    for (int i = 0; i < n; i++)
                    begin
                        logic [srf_pkg::DATA_W-1:0] s;
                        s = ring_words[rd_slot];
                        rd_slot = (rd_slot + 1 >= srf_pkg::SLOTS) ? 0 : rd_slot + 1;
                        queue_result(1'b1, s, 1'b1, i == n - 1);
                    end
            end
            default:
                queue_result(1'b0, '0, 1'b0, 1'b1);
        endcase
    endtask

    // Offer one request after a random gap and wait until it is taken
    task automatic send_request(input logic [srf_pkg::CMD_W-1:0] cmd,
                                input logic [srf_pkg::DATA_W-1:0] val,
                                input logic [srf_pkg::LEN_W-1:0] cnt,
                                input logic start);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        command      <= cmd;
        sample_value <= val;
        count        <= cnt;
        block_start  <= start;
        do
            @(posedge clk);
        while (req_stall);
        predict_request(cmd, val, cnt, start);
    endtask

    // Block write: count on the first element, then elems elements in all
    task automatic send_block(input int cnt, input int elems);
        for (int i = 0; i < elems; i++)
            send_request(srf_pkg::CMD_WRITE, $urandom,
                         (i == 0) ? srf_pkg::LEN_W'(cnt)
                                  : srf_pkg::LEN_W'($urandom_range(0, 127)),
                         i == 0);
    endtask

    // Hold off new requests until every predicted result has arrived
    task automatic drain_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic report_mismatch(input string what,
                                   input logic [srf_pkg::DATA_W-1:0] got,
                                   input logic [srf_pkg::DATA_W-1:0] want);
        err_count++;
        $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // Result checker: compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        srf_pkg::res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", sample_out, '0);
            else
            begin
                want = pending_results.pop_front();
                if (accepted !== want.accepted)
                    report_mismatch("accepted", srf_pkg::DATA_W'(accepted),
                                    srf_pkg::DATA_W'(want.accepted));
                if (sample_out !== want.sample_out)
                    report_mismatch("sample_out", sample_out, want.sample_out);
                if (sample_valid !== want.sample_valid)
                    report_mismatch("sample_valid", srf_pkg::DATA_W'(sample_valid),
                                    srf_pkg::DATA_W'(want.sample_valid));
                if (last !== want.last)
                    report_mismatch("last", srf_pkg::DATA_W'(last),
                                    srf_pkg::DATA_W'(want.last));
                if (occupancy !== want.occupancy)
                    report_mismatch("occupancy", srf_pkg::DATA_W'(occupancy),
                                    srf_pkg::DATA_W'(want.occupancy));
            end
        end
    end

    // Result-side stall: random stretches, off while calm
    initial
    begin : rx_stall_gen
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (calm)
                res_stall <= 1'b0;
            else if ($urandom_range(0, 99) < 35)
            begin
                res_stall <= 1'b1;
                hold = idle_len();
            end
            else
            begin
                res_stall <= 1'b0;
                hold = $urandom_range(0, 6);
            end
        end
    end

    // Empty ring: zero and oversize reads, empty fill, unknown command, stray element
    task automatic test_empty_edges();
        send_request(srf_pkg::CMD_READ, $urandom, 7'd0, 1'b0);
        send_request(srf_pkg::CMD_READ, $urandom, 7'd1, 1'b0);
        send_request(srf_pkg::CMD_FILL, $urandom, 7'd0, 1'b0);
        send_request(CMD_UNUSED, 32'hFFFF_FFFF, 7'h7F, 1'b1);
        send_request(srf_pkg::CMD_WRITE, $urandom, 7'd3, 1'b0);
    endtask

    // Block writes: empty block, extremes, stray, cut-short block, fill and read mid-block
    task automatic test_block_writes();
        send_block(0, 1);
        send_request(srf_pkg::CMD_WRITE, 32'h0000_0000, 7'd3, 1'b1);
        send_request(srf_pkg::CMD_WRITE, 32'hFFFF_FFFF, 7'd0, 1'b0);
        send_request(srf_pkg::CMD_WRITE, 32'h5555_AAAA, 7'h7F, 1'b0);
        send_request(srf_pkg::CMD_WRITE, $urandom, 7'd1, 1'b0);
        send_block(4, 1);
        send_block(2, 2);
        send_block(5, 1);
        send_request(srf_pkg::CMD_FILL, 32'hAAAA_5555, 7'h7F, 1'b0);
        send_request(srf_pkg::CMD_READ, $urandom, 7'h7F, 1'b0);
        for (int i = 0; i < 4; i++)
            send_request(srf_pkg::CMD_WRITE, $urandom, 7'd0, 1'b0);
    endtask

    // Fill to the brim, then show that fills and blocks are refused and reads still work
    task automatic test_full_store();
        while (ring_free() >= srf_pkg::MAX_BURST)
            send_request(srf_pkg::CMD_FILL, $urandom,
                         srf_pkg::LEN_W'(srf_pkg::MAX_BURST), 1'b0);
        if (ring_free() > 0)
            send_request(srf_pkg::CMD_FILL, $urandom, srf_pkg::LEN_W'(ring_free()), 1'b0);
        send_request(srf_pkg::CMD_FILL, $urandom, 7'd1, 1'b0);
        send_block(2, 2);
        send_request(srf_pkg::CMD_READ, $urandom, 7'h7F, 1'b0);
        send_request(srf_pkg::CMD_READ, $urandom, 7'd0, 1'b0);
    endtask

    // Random traffic: mostly well-formed blocks, fills and reads, some noise
    task automatic test_random_traffic();
        int  sent;
        int  pick;
        int  n;
        int  elems;
        bit  paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_REQUESTS)
        begin
            calm = (sent < 40);
            if (sent >= RANDOM_REQUESTS / 2 && !paused)
            begin
                drain_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 88)
                    n = $urandom_range(1, 6);
                else if (pick < 96)
                    n = $urandom_range(7, srf_pkg::MAX_BURST);
                else
                    n = $urandom_range(srf_pkg::MAX_BURST + 1, 127);
                elems = (n > srf_pkg::MAX_BURST) ? srf_pkg::MAX_BURST : n;
                // now and then cut the block short
                if (elems > 1 && $urandom_range(0, 9) == 0)
                    elems = $urandom_range(1, elems - 1);
                send_block(n, elems);
                sent += elems;
            end
            else if (pick < 55)
            begin
                if ($urandom_range(0, 9) < 8)
                    n = $urandom_range(0, 12);
                else
                    n = $urandom_range(0, 127);
                send_request(srf_pkg::CMD_FILL, $urandom, srf_pkg::LEN_W'(n),
                             1'($urandom_range(0, 1)));
                sent++;
            end
            else if (pick < 90)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    n = $urandom_range(0, (ring_used() < 16) ? ring_used() : 16);
                else if (pick < 90)
                    n = $urandom_range(0, (ring_used() < srf_pkg::MAX_BURST) ?
                                          ring_used() : srf_pkg::MAX_BURST);
                else
                    n = $urandom_range(0, 127);
                send_request(srf_pkg::CMD_READ, $urandom, srf_pkg::LEN_W'(n),
                             1'($urandom_range(0, 1)));
                sent++;
            end
            else if (pick < 95)
                send_request(srf_pkg::CMD_WRITE, $urandom,
                             srf_pkg::LEN_W'($urandom_range(0, 127)), 1'b0);
            else
                send_request(CMD_UNUSED, $urandom, srf_pkg::LEN_W'($urandom_range(0, 127)),
                             1'($urandom_range(0, 1)));
        end
        calm = 1'b0;
    endtask

    initial
    begin
        wr_slot   = 0;
        rd_slot   = 0;
        blk_taken = 1'b0;
        blk_left  = 0;
        err_count = 0;
        calm      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_empty_edges();
        test_block_writes();
        test_full_store();
        drain_results();
        test_random_traffic();

        // wait out the last results and any fill still in progress
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("sample_ring_fifo_top_test: clean");
        else
            $display("sample_ring_fifo_top_test: errors");
        $finish;
    end

endmodule
